// File: rtl/pss_pkg.sv
// Package for the profiling slot statistics block: sizes, codes and item types.
`default_nettype none

package pss_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int TAG_BITS   = 16;
    localparam int IDX_W      = $clog2(SLOT_COUNT);

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_FULL       = 2'd1;
    localparam logic [1:0] STAT_NOT_ACTIVE = 2'd2;
    localparam logic [1:0] STAT_EMPTY      = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] tag_id;
        logic [4:0]  handle;
        logic [31:0] timestamp;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot_index;
        logic [31:0] call_count;
        logic [63:0] total_cycles;
        logic [31:0] min_cycles;
        logic [31:0] max_cycles;
        logic        is_active;
    } rsp_t;

    // One statistics RAM word per slot.
    typedef struct packed {
        logic [31:0] start_time;
        logic [63:0] sum_cycles;
        logic [31:0] done_count;
        logic [31:0] least_cycles;
        logic [31:0] most_cycles;
    } stat_entry_t;

    localparam int STAT_W = $bits(stat_entry_t);

    localparam stat_entry_t STAT_RESET = '{
        start_time:   32'd0,
        sum_cycles:   64'd0,
        done_count:   32'd0,
        least_cycles: 32'hFFFF_FFFF,
        most_cycles:  32'd0
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_PICK,
        S_ELAP,
        S_WRITE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/pss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/profiling_slot_statistics.sv
// Top level of the profiling slot statistics block.
`default_nettype none

// A table of SLOT_COUNT measurement slots keyed by tag id. Each request item
// (begin, end, read, none) yields exactly one response item. The block works
// on one item at a time. An item is accepted in the idle cycle. Its response
// is loaded into the output register after the states tag compare, slot pick
// and RAM read issue, RAM read data and elapsed-time subtract, then 64-bit
// add / min / max and write back. The request side is ready again in the
// cycle after that load, so a new item is not taken before the previous one
// is through; this is set by the read-modify-write of the single statistics
// RAM with its registered read. The response register frees the request
// side once it is loaded; a new item waits only if the previous response is
// still held when its own write-back stage is reached, and it stays in that
// stage for as long as the hold lasts.
// Occupancy, tags and running flags sit in flip-flops next to the tag
// comparators; start time, total, count, min and max sit in the RAM, with one
// valid flop per slot so that a slot never written reads as its reset value.
// No clearing pass is needed after reset.
module profiling_slot_statistics
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire pss_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output pss_pkg::rsp_t      rsp
);

    import pss_pkg::*;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    req_t               item_reg;
    logic [SLOT_COUNT-1:0] match_reg;
    logic [SLOT_COUNT-1:0] free_reg;
    logic [IDX_W-1:0]   op_idx_reg;
    logic               hit_reg;
    logic               free_any_reg;
    logic               in_range_reg;
    stat_entry_t        stat_reg;
    logic [31:0]        elapsed_reg;

    // Per-slot flops: occupancy, tag, running flag, RAM word valid.
    logic [SLOT_COUNT-1:0] used_reg;
    logic [SLOT_COUNT-1:0] running_reg;
    logic [SLOT_COUNT-1:0] stat_valid_reg;
    logic [TAG_BITS-1:0]   tag_reg [SLOT_COUNT];

    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg;

    // Output-block controls
    logic ram_re;
    logic in_take;
    logic load_rsp;

    // ------------------------------------------------------------------
    // Field decode
    // ------------------------------------------------------------------
    logic [TAG_BITS+15:0] tag_wide;
    logic [TAG_BITS-1:0]  tag_key;
    logic [IDX_W+4:0]     h_wide;
    logic [IDX_W-1:0]     h_idx;
    logic                 h_in_range;
    logic [IDX_W+4:0]     pick_wide;

    assign tag_wide   = (TAG_BITS+16)'(item_reg.tag_id);
    assign tag_key    = tag_wide[TAG_BITS-1:0];
    assign h_wide     = (IDX_W+5)'(item_reg.handle);
    assign h_idx      = h_wide[IDX_W-1:0];
    assign h_in_range = h_wide < (IDX_W+5)'(SLOT_COUNT);
    assign pick_wide  = (IDX_W+5)'(op_idx_reg);

    // ------------------------------------------------------------------
    // Tag search: comparators per slot, registered, then priority pick
    // ------------------------------------------------------------------
    logic [SLOT_COUNT-1:0] match_vec;

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            match_vec[i] = used_reg[i] && (tag_reg[i] == tag_key);
        end
    end

    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;

    // lowest set bit wins
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    logic [IDX_W-1:0] pick_idx;

    always_comb
    begin
        priority if (item_reg.command != CMD_BEGIN)
        begin
            pick_idx = h_idx;
        end
        else if (|match_reg)
        begin
            pick_idx = hit_idx;
        end
        else
        begin
            pick_idx = free_idx;
        end
    end

    // ------------------------------------------------------------------
    // Statistics RAM
    // ------------------------------------------------------------------
    stat_entry_t ram_rdata;
    stat_entry_t ram_wdata;
    logic        ram_we;
    stat_entry_t stat_cur;

    pss_ram #(
        .WIDTH (STAT_W),
        .DEPTH (SLOT_COUNT)
    ) u_stat_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pick_idx),
        .rdata (ram_rdata)
    );

    // never-written words read as their reset value
    assign stat_cur = stat_valid_reg[op_idx_reg] ? ram_rdata : STAT_RESET;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH: state_next = S_PICK;
            S_PICK:  state_next = S_ELAP;
            S_ELAP:  state_next = S_WRITE;
            S_WRITE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        req_ready = 1'b0;
        ram_re    = 1'b0;
        load_rsp  = 1'b0;
        unique case (state_reg)
            S_IDLE:  req_ready = 1'b1;
            S_MATCH: ;
            S_PICK:  ram_re = 1'b1;
            S_ELAP:  ;
            S_WRITE: load_rsp = !rsp_valid_reg || rsp_ready;
            default: ;
        endcase
    end

    assign in_take = req_valid && req_ready;

    // ------------------------------------------------------------------
    // Write-back and response formation
    // ------------------------------------------------------------------
    logic        upd_begin;
    logic        upd_end;
    stat_entry_t stat_new;

    always_comb
    begin
        upd_begin = 1'b0;
        upd_end   = 1'b0;
        stat_new  = stat_reg;
        rsp_next  = '0;
        rsp_next.slot_index = item_reg.handle;

        unique case (item_reg.command)
            CMD_BEGIN:
            begin
                if (!hit_reg && !free_any_reg)
                begin
                    rsp_next.status     = STAT_FULL;
                    rsp_next.slot_index = '0;
                end
                else
                begin
                    upd_begin           = 1'b1;
                    stat_new.start_time = item_reg.timestamp;
                    rsp_next.status     = STAT_OK;
                    rsp_next.slot_index = pick_wide[4:0];
                    rsp_next.is_active  = 1'b1;
                end
            end
            CMD_END:
            begin
                rsp_next.status = STAT_NOT_ACTIVE;
                if (in_range_reg)
                begin
                    if (running_reg[op_idx_reg])
                    begin
                        upd_end              = 1'b1;
                        rsp_next.status      = STAT_OK;
                        stat_new.sum_cycles  = stat_reg.sum_cycles + 64'(elapsed_reg);
                        stat_new.done_count  = stat_reg.done_count + 32'd1;
                        if (elapsed_reg < stat_reg.least_cycles)
                        begin
                            stat_new.least_cycles = elapsed_reg;
                        end
                        if (elapsed_reg > stat_reg.most_cycles)
                        begin
                            stat_new.most_cycles = elapsed_reg;
                        end
                    end
                    rsp_next.is_active = 1'b0;
                end
            end
            CMD_READ:
            begin
                rsp_next.status = STAT_EMPTY;
                if (in_range_reg)
                begin
                    rsp_next.status    = used_reg[op_idx_reg] ? STAT_OK : STAT_EMPTY;
                    rsp_next.is_active = running_reg[op_idx_reg];
                end
            end
            CMD_NONE:
            begin
                rsp_next.status = STAT_OK;
            end
            default: ;
        endcase

        // statistics fields for every case that shows the slot
        if (upd_begin || ((item_reg.command == CMD_END || item_reg.command == CMD_READ)
                          && in_range_reg))
        begin
            rsp_next.call_count   = stat_new.done_count;
            rsp_next.total_cycles = stat_new.sum_cycles;
            rsp_next.min_cycles   = stat_new.least_cycles;
            rsp_next.max_cycles   = stat_new.most_cycles;
        end
    end

    assign ram_we    = load_rsp && (upd_begin || upd_end);
    assign ram_wdata = stat_new;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            running_reg    <= '0;
            stat_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                stat_valid_reg[op_idx_reg] <= 1'b1;
            end
            if (load_rsp && upd_begin)
            begin
                used_reg[op_idx_reg]    <= 1'b1;
                running_reg[op_idx_reg] <= 1'b1;
            end
            if (load_rsp && upd_end)
            begin
                running_reg[op_idx_reg] <= 1'b0;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= req;
        end
        if (state_reg == S_MATCH)
        begin
            match_reg <= match_vec;
            free_reg  <= ~used_reg;
        end
        if (state_reg == S_PICK)
        begin
            op_idx_reg   <= pick_idx;
            hit_reg      <= |match_reg;
            free_any_reg <= |free_reg;
            in_range_reg <= h_in_range;
        end
        if (state_reg == S_ELAP)
        begin
            stat_reg    <= stat_cur;
            elapsed_reg <= item_reg.timestamp - stat_cur.start_time;
        end
        if (load_rsp && upd_begin)
        begin
            tag_reg[op_idx_reg] <= tag_key;
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/pss_checker.sv
// Port-level assertions for the profiling slot statistics block, with bind.
`default_nettype none

module pss_checker
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire pss_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire pss_pkg::rsp_t rsp
);

    import pss_pkg::*;

    // held response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item accepted while one is in flight");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |->
            rsp.slot_index == 5'd0 && rsp.call_count == 32'd0 &&
            rsp.total_cycles == 64'd0 && rsp.min_cycles == 32'd0 &&
            rsp.max_cycles == 32'd0 && !rsp.is_active)
        else $error("table-full response carries statistics");

    // a slot that was never claimed has never been measured
    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_EMPTY |->
            rsp.call_count == 32'd0 && rsp.total_cycles == 64'd0 && !rsp.is_active)
        else $error("empty slot shows activity");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.call_count != 32'd0 && rsp.status != STAT_FULL |->
            rsp.min_cycles <= rsp.max_cycles)
        else $error("min above max in a measured slot");

endmodule

bind profiling_slot_statistics pss_checker u_pss_checker (.*);

`default_nettype wire
